// ===== rtl/mcfp_pkg.sv =====
// Shared types, constants and helpers of the motion command frame parser.
// No dependencies; the datapath, the sequencer and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none
package mcfp_pkg;

	localparam int HOLD_DEPTH = 32;
	localparam int PW = $clog2(HOLD_DEPTH);
	localparam int CW = $clog2(HOLD_DEPTH + 1);

	typedef logic [PW-1:0] ptr_t;
	typedef logic [CW-1:0] cnt_t;

	localparam logic [7:0] HEAD_BYTE   = 8'hDF;
	localparam logic [7:0] TAIL_BYTE   = 8'hFD;
	localparam logic [7:0] VEL_TYPE_B  = 8'h67;
	localparam logic [7:0] VEL_LEN_B   = 8'h06;
	localparam logic [7:0] DISP_TYPE_B = 8'h64;
	localparam logic [7:0] DISP_LEN_B  = 8'd14;
	localparam int VEL_FRAME_LEN  = 14;
	localparam int DISP_FRAME_LEN = 22;
	localparam int HDR_LEN        = 6;
	localparam int FIELD_START    = 6;
	localparam int VEL_FIELD_END  = 11;
	localparam int DISP_FIELD_END = 19;
	localparam int FIELD_BYTES    = 14;
	localparam logic [16:0] IDLE_MAX = 17'h1FFFF;

	localparam logic [7:0]  DEST_RESET    = 8'h01;
	localparam logic [7:0]  SOURCE_RESET  = 8'h97;
	localparam logic [7:0]  TYPE_RESET    = 8'h02;
	localparam logic [15:0] TIMEOUT_RESET = 16'd100;

	localparam logic [1:0] REG_DEST    = 2'd0;
	localparam logic [1:0] REG_SOURCE  = 2'd1;
	localparam logic [1:0] REG_TYPE    = 2'd2;
	localparam logic [1:0] REG_TIMEOUT = 2'd3;

	typedef struct packed {
		logic push;
		logic tick;
		logic drop;
		cnt_t drop_len;
		ptr_t rd_offset;
		logic sum_add;
		logic capture;
		logic emit;
		logic kind;
	} dp_cmd_t;

	typedef struct packed {
		cnt_t       count;
		logic [7:0] rd_byte;
		logic       cfg_match;
		logic       sum_match;
		logic       out_free;
	} dp_status_t;

	// Circular buffer index addition; both operands are below HOLD_DEPTH.
	function automatic ptr_t ptr_add(ptr_t a, ptr_t b);
		logic [PW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (PW + 1)'(HOLD_DEPTH))
			s = s - (PW + 1)'(HOLD_DEPTH);
		return s[PW-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/mcfp_in_if.sv =====
// Input channel of the frame parser: received bytes and millisecond ticks.
// Stand-alone interface, no dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface mcfp_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] data_byte;

	modport source (output valid, output mode, output data_byte, input ready);
	modport sink (input valid, input mode, input data_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/mcfp_out_if.sv =====
// Result channel of the frame parser: one decoded motion command per transaction.
// Stand-alone interface, no dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface mcfp_out_if;
	logic               valid;
	logic               ready;
	logic               frame_kind;
	logic signed [31:0] x_value;
	logic signed [31:0] y_value;
	logic signed [31:0] turn_value;
	logic [15:0]        target_speed;

	modport source (output valid, output frame_kind, output x_value, output y_value,
		output turn_value, output target_speed, input ready);
	modport sink (input valid, input frame_kind, input x_value, input y_value,
		input turn_value, input target_speed, output ready);
endinterface
`default_nettype wire

// ===== rtl/mcfp_datapath.sv =====
// Datapath of the frame parser: byte holding memory, counters, config registers,
// checksum, field capture and the result register. Depends on mcfp_pkg, mcfp_out_if.
`timescale 1ns / 1ps
`default_nettype none
module mcfp_datapath
	import mcfp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] data_byte,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire dp_cmd_t    cmd,
	output dp_status_t      status,
	mcfp_out_if.source      out_ch
);

	logic [7:0]  mem [HOLD_DEPTH];
	logic [7:0]  rd_q;
	ptr_t        head_q;
	cnt_t        count_q;
	logic [16:0] idle_q;
	logic [7:0]  dest_q, source_q, type_q;
	logic [15:0] timeout_q;
	logic [7:0]  sum_q;
	logic [7:0]  fld_q [FIELD_BYTES];
	logic        out_valid_q;

	cnt_t c0;
	logic full;
	ptr_t head_p, wr_addr, rd_addr;
	logic [7:0] cfg_sel;

	always_comb begin
		c0 = (count_q != '0 && idle_q > {1'b0, timeout_q}) ? '0 : count_q;
		full = (c0 == CW'(HOLD_DEPTH));
		head_p = full ? ptr_add(head_q, PW'(1)) : head_q;
		wr_addr = ptr_add(head_p, full ? PW'(HOLD_DEPTH - 1) : c0[PW-1:0]);
		rd_addr = ptr_add(head_q, cmd.rd_offset);
		case (cmd.rd_offset)
			PW'(1): cfg_sel = dest_q;
			PW'(2): cfg_sel = source_q;
			PW'(3): cfg_sel = type_q;
			default: cfg_sel = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.push)
			mem[wr_addr] <= data_byte;
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= '0;
			idle_q <= '0;
			dest_q <= DEST_RESET;
			source_q <= SOURCE_RESET;
			type_q <= TYPE_RESET;
			timeout_q <= TIMEOUT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DEST:    dest_q <= cfg_data[7:0];
					REG_SOURCE:  source_q <= cfg_data[7:0];
					REG_TYPE:    type_q <= cfg_data[7:0];
					REG_TIMEOUT: timeout_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.tick && idle_q != IDLE_MAX)
				idle_q <= idle_q + 17'd1;
			if (cmd.push) begin
				idle_q <= '0;
				head_q <= head_p;
				count_q <= full ? CW'(HOLD_DEPTH) : c0 + CW'(1);
			end else if (cmd.drop) begin
				head_q <= ptr_add(head_q, cmd.drop_len[PW-1:0]);
				count_q <= count_q - cmd.drop_len;
			end
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_add)
			sum_q <= (cmd.rd_offset == '0) ? rd_q : sum_q + rd_q;
		if (cmd.capture) begin
			for (int i = 0; i < FIELD_BYTES - 1; i++)
				fld_q[i] <= fld_q[i+1];
			fld_q[FIELD_BYTES-1] <= rd_q;
		end
		if (cmd.emit) begin
			out_ch.frame_kind <= cmd.kind;
			if (cmd.kind) begin
				out_ch.x_value <= {fld_q[3], fld_q[2], fld_q[1], fld_q[0]};
				out_ch.y_value <= {fld_q[7], fld_q[6], fld_q[5], fld_q[4]};
				out_ch.turn_value <= {fld_q[11], fld_q[10], fld_q[9], fld_q[8]};
				out_ch.target_speed <= {fld_q[13], fld_q[12]};
			end else begin
				// Velocity fields sit in the upper six bytes of the capture line.
				out_ch.x_value <= {{16{fld_q[9][7]}}, fld_q[9], fld_q[8]};
				out_ch.y_value <= {{16{fld_q[11][7]}}, fld_q[11], fld_q[10]};
				out_ch.turn_value <= {{16{fld_q[13][7]}}, fld_q[13], fld_q[12]};
				out_ch.target_speed <= '0;
			end
		end
	end

	assign out_ch.valid = out_valid_q;

	always_comb begin
		status.count = count_q;
		status.rd_byte = rd_q;
		status.cfg_match = (rd_q == cfg_sel);
		status.sum_match = (rd_q == sum_q);
		status.out_free = !out_valid_q || out_ch.ready;
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(HOLD_DEPTH)) else $error("held count beyond depth");
	a_drop_held: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.drop |-> (cmd.drop_len <= count_q && cmd.drop_len != '0))
		else $error("drop larger than held bytes");
	a_push_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> count_q != '0) else $error("pushed byte not held");
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q) else $error("result not presented");
`endif

endmodule
`default_nettype wire

// ===== rtl/mcfp_ctrl.sv =====
// Sequencer of the frame parser: syncs on the head byte, walks the header and
// the frame body through the datapath read port. Depends on mcfp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mcfp_ctrl
	import mcfp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_mode,
	output logic            in_ready,
	input  wire dp_status_t status,
	output dp_cmd_t         cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_SYNC_RD, S_SYNC_CHK, S_HDR_RD, S_HDR_CHK, S_SUM_RD, S_SUM_CHK, S_EMIT
	} state_t;

	state_t state_q;
	ptr_t   offset_q;
	logic   disp_q;

	cnt_t flen;
	ptr_t last_field;
	logic hdr_ok, tail_bad, sum_last;

	always_comb begin
		flen = disp_q ? CW'(DISP_FRAME_LEN) : CW'(VEL_FRAME_LEN);
		last_field = disp_q ? PW'(DISP_FIELD_END) : PW'(VEL_FIELD_END);
		case (offset_q)
			PW'(4): hdr_ok = (status.rd_byte == VEL_TYPE_B) || (status.rd_byte == DISP_TYPE_B);
			PW'(5): hdr_ok = status.rd_byte == (disp_q ? DISP_LEN_B : VEL_LEN_B);
			default: hdr_ok = status.cfg_match;
		endcase
		sum_last = ({1'b0, offset_q} == (PW + 1)'(flen - CW'(1)));
		tail_bad = ({1'b0, offset_q} == (PW + 1)'(flen - CW'(2)))
			&& (status.rd_byte != TAIL_BYTE);
	end

	always_comb begin
		in_ready = (state_q == S_IDLE);
		cmd = '0;
		cmd.push = in_ready && in_valid && !in_mode;
		cmd.tick = in_ready && in_valid && in_mode;
		cmd.rd_offset = offset_q;
		cmd.kind = disp_q;
		cmd.drop_len = CW'(1);
		case (state_q)
			S_SYNC_CHK: cmd.drop = (status.rd_byte != HEAD_BYTE);
			S_HDR_CHK:  cmd.drop = !hdr_ok;
			S_SUM_CHK: begin
				cmd.drop = tail_bad || (sum_last && !status.sum_match);
				cmd.sum_add = !sum_last;
				cmd.capture = (offset_q >= PW'(FIELD_START)) && (offset_q <= last_field);
			end
			S_EMIT: begin
				cmd.emit = status.out_free;
				cmd.drop = status.out_free;
				cmd.drop_len = flen;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			offset_q <= '0;
			disp_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					offset_q <= '0;
					if (cmd.push)
						state_q <= S_SYNC_RD;
				end
				S_SYNC_RD: state_q <= (status.count == '0) ? S_IDLE : S_SYNC_CHK;
				S_SYNC_CHK: begin
					if (status.rd_byte != HEAD_BYTE)
						state_q <= S_SYNC_RD;
					else if (status.count < CW'(HDR_LEN))
						state_q <= S_IDLE;
					else begin
						offset_q <= PW'(1);
						state_q <= S_HDR_RD;
					end
				end
				S_HDR_RD: state_q <= S_HDR_CHK;
				S_HDR_CHK: begin
					if (offset_q == PW'(4))
						disp_q <= (status.rd_byte == DISP_TYPE_B);
					if (!hdr_ok) begin
						offset_q <= '0;
						state_q <= S_SYNC_RD;
					end else if (offset_q == PW'(5)) begin
						offset_q <= '0;
						state_q <= (status.count < flen) ? S_IDLE : S_SUM_RD;
					end else begin
						offset_q <= offset_q + PW'(1);
						state_q <= S_HDR_RD;
					end
				end
				S_SUM_RD: state_q <= S_SUM_CHK;
				S_SUM_CHK: begin
					if (cmd.drop) begin
						offset_q <= '0;
						state_q <= S_SYNC_RD;
					end else if (sum_last)
						state_q <= S_EMIT;
					else begin
						offset_q <= offset_q + PW'(1);
						state_q <= S_SUM_RD;
					end
				end
				S_EMIT: begin
					if (status.out_free) begin
						offset_q <= '0;
						state_q <= S_SYNC_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> !in_ready) else $error("byte accepted while busy");
	a_sync_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SYNC_RD) |-> offset_q == '0) else $error("sync read not at front");
	a_emit_len: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.count >= flen) else $error("frame emitted while short");
`endif

endmodule
`default_nettype wire

// ===== rtl/motion_command_frame_parser.sv =====
// Top level of the motion command frame parser: sequencer plus datapath.
// Depends on mcfp_pkg, mcfp_in_if, mcfp_out_if, mcfp_ctrl and mcfp_datapath.
//
// Each input transaction is a byte or a millisecond tick. After a byte the
// sequencer reads held bytes one at a time, since the holding memory has one
// read port with registered data: a sync check on the head byte, a header
// check, then a checksum walk over the velocity or displacement frame; each
// mismatch drops one byte and rescans from the new front. ready is high only
// while the sequencer is idle. A decoded frame waits in the result register
// without blocking the next byte; the sequencer stalls only when a second
// frame is due before the first is taken. No clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none
module motion_command_frame_parser
	import mcfp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	mcfp_in_if.sink          byte_ch,
	mcfp_out_if.source       result_ch,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	mcfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (byte_ch.valid),
		.in_mode  (byte_ch.mode),
		.in_ready (byte_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	mcfp_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (byte_ch.data_byte),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_ch    (result_ch)
	);

endmodule
`default_nettype wire
